/* rtl/scc_pkg.sv */
// Shared types, widths and register codes of the sight cone containment test.
package scc_pkg;

   // Coordinate width of every input field.
   localparam int COORD_BITS = 20;

   // Fixed widths of the register fields.
   localparam int AXIS_BITS     = 16;
   localparam int OFFSET_BITS   = 16;
   localparam int RADIUS_BITS   = 44;
   localparam int FRAC_BITS     = 15;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = RADIUS_BITS;

   // Apex set-back: Q1.15 axis times unsigned offset, then rounded to units.
   localparam int PROD_BITS = AXIS_BITS + OFFSET_BITS + 1;
   localparam int APEX_BITS = PROD_BITS - FRAC_BITS;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   // Vector from the apex to the target and its derived quantities.
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int VEC_BITS  = ((DIFF_BITS > APEX_BITS) ? DIFF_BITS : APEX_BITS) + 1;
   localparam int SQF_BITS  = 2 * VEC_BITS;
   localparam int SQ_BITS   = SQF_BITS - 1;
   localparam int LEN_BITS  = SQF_BITS;
   localparam int LEN_LO    = LEN_BITS / 2;
   localparam int LEN_HI    = LEN_BITS - LEN_LO;
   localparam int CMP_BITS  = (LEN_BITS > RADIUS_BITS) ? LEN_BITS : RADIUS_BITS;
   localparam int DOTP_BITS = VEC_BITS + AXIS_BITS;
   localparam int DOT_BITS  = DOTP_BITS + 2;
   localparam int MAG_BITS  = VEC_BITS + AXIS_BITS;
   localparam int MAG_LO    = MAG_BITS / 2;
   localparam int MAG_HI    = MAG_BITS - MAG_LO;
   localparam int COS_MAG_BITS = AXIS_BITS;
   localparam int ACSQ_BITS = 2 * COS_MAG_BITS - 1;
   localparam int WIDE_BITS = 2 * MAG_BITS;

   // Stream payload widths.
   localparam int REQ_FIELDS    = 6;
   localparam int REQ_DATA_BITS = 8 * ((REQ_FIELDS * COORD_BITS + 7) / 8);
   localparam int RSP_DATA_BITS = 8;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DIR_X          = 3'd0,
      REG_DIR_Y          = 3'd1,
      REG_DIR_Z          = 3'd2,
      REG_HALF_ANGLE_COS = 3'd3,
      REG_BACK_OFFSET    = 3'd4,
      REG_NEAR_RADIUS_SQ = 3'd5,
      REG_FAR_RADIUS_SQ  = 3'd6
   } reg_index_type;

   // Register values after reset.
   localparam logic signed [AXIS_BITS-1:0] DIR_X_RESET = 16'sd32767;
   localparam logic signed [AXIS_BITS-1:0] DIR_Y_RESET = 16'sd0;
   localparam logic signed [AXIS_BITS-1:0] DIR_Z_RESET = 16'sd0;
   localparam logic signed [AXIS_BITS-1:0] COS_RESET   = 16'sd23170;
   localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = '0;
   localparam logic [RADIUS_BITS-1:0] NEAR_RESET   = '0;
   localparam logic [RADIUS_BITS-1:0] FAR_RESET    = '1;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic signed [AXIS_BITS-1:0] dir_x;
      logic signed [AXIS_BITS-1:0] dir_y;
      logic signed [AXIS_BITS-1:0] dir_z;
      logic signed [AXIS_BITS-1:0] half_angle_cos;
      logic [OFFSET_BITS-1:0]      back_offset;
      logic [RADIUS_BITS-1:0]      near_radius_sq;
      logic [RADIUS_BITS-1:0]      far_radius_sq;
   } cfg_type;

   // One query item.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic signed [COORD_BITS-1:0] origin_z;
      logic signed [COORD_BITS-1:0] target_x;
      logic signed [COORD_BITS-1:0] target_y;
      logic signed [COORD_BITS-1:0] target_z;
   } query_type;

   // Geometry handed from the vector pipeline to the decision pipeline.
   typedef struct packed {
      logic [LEN_BITS-1:0]        len;
      logic signed [DOT_BITS-1:0] dot;
      logic [ACSQ_BITS-1:0]       acsq;
      logic                       cos_neg;
   } geom_type;

endpackage

/* rtl/scc_geom.sv */
// Four-stage vector pipeline: apex set-back, vector, squares, length and dot product.
module scc_geom (
   input  logic               clock,
   input  logic               reset,
   input  scc_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  scc_pkg::query_type query,
   output logic               out_valid,
   input  logic               out_ready,
   output scc_pkg::geom_type  geom
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;

   logic signed [scc_pkg::COORD_BITS-1:0] org [3];
   logic signed [scc_pkg::COORD_BITS-1:0] tgt [3];
   logic signed [scc_pkg::AXIS_BITS-1:0]  dir [3];

   logic signed [scc_pkg::DIFF_BITS-1:0] diff_ff [3];
   logic signed [scc_pkg::DIFF_BITS-1:0] diff_in [3];
   logic signed [scc_pkg::PROD_BITS-1:0] prod_ff [3];
   logic signed [scc_pkg::PROD_BITS-1:0] prod_in [3];
   logic signed [scc_pkg::PROD_BITS-1:0] rnd     [3];
   logic signed [scc_pkg::VEC_BITS-1:0]  vec_ff  [3];
   logic signed [scc_pkg::VEC_BITS-1:0]  vec_in  [3];
   logic signed [scc_pkg::SQF_BITS-1:0]  sqf     [3];
   logic [scc_pkg::SQ_BITS-1:0]          sq_ff   [3];
   logic [scc_pkg::SQ_BITS-1:0]          sq_in   [3];
   logic signed [scc_pkg::DOTP_BITS-1:0] dotp_ff [3];
   logic signed [scc_pkg::DOTP_BITS-1:0] dotp_in [3];

   logic [scc_pkg::COS_MAG_BITS-1:0] cos_mag;
   logic [scc_pkg::ACSQ_BITS-1:0]    acsq3_ff, acsq3_in;
   logic                             cneg3_ff, cneg3_in;
   scc_pkg::geom_type                geom_ff, geom_in;

   // Per-stage advance: a stage loads when it is empty or the next one moves.
   assign adv4 = !v4_ff || out_ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign in_ready = adv1;

   assign v1_in = adv1 ? in_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Axis-wise views of the item and the cone axis.
   always_comb begin
      org[0] = query.origin_x;
      org[1] = query.origin_y;
      org[2] = query.origin_z;
      tgt[0] = query.target_x;
      tgt[1] = query.target_y;
      tgt[2] = query.target_z;
      dir[0] = cfg.dir_x;
      dir[1] = cfg.dir_y;
      dir[2] = cfg.dir_z;
   end

   // Stage 1: raw difference and the Q.15 set-back product.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff_in[a] = scc_pkg::DIFF_BITS'(tgt[a]) - scc_pkg::DIFF_BITS'(org[a]);
         prod_in[a] = scc_pkg::PROD_BITS'(dir[a])
                    * scc_pkg::PROD_BITS'($signed({1'b0, cfg.back_offset}));
      end
   end

   // Stage 2: round the set-back half up to whole units and add it.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         rnd[a] = prod_ff[a] + scc_pkg::PROD_BITS'(scc_pkg::ROUND_HALF);
         vec_in[a] = scc_pkg::VEC_BITS'(diff_ff[a])
                   + scc_pkg::VEC_BITS'($signed(rnd[a][scc_pkg::PROD_BITS-1:scc_pkg::FRAC_BITS]));
      end
   end

   // Stage 3: squares of the components and their products with the axis.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sqf[a] = scc_pkg::SQF_BITS'(vec_ff[a]) * scc_pkg::SQF_BITS'(vec_ff[a]);
         sq_in[a] = sqf[a][scc_pkg::SQ_BITS-1:0];
         dotp_in[a] = scc_pkg::DOTP_BITS'(vec_ff[a]) * scc_pkg::DOTP_BITS'(dir[a]);
      end
      cos_mag = scc_pkg::COS_MAG_BITS'(cfg.half_angle_cos[scc_pkg::AXIS_BITS-1]
                                       ? -cfg.half_angle_cos : cfg.half_angle_cos);
      acsq3_in = scc_pkg::ACSQ_BITS'(32'(cos_mag) * 32'(cos_mag));
      cneg3_in = cfg.half_angle_cos[scc_pkg::AXIS_BITS-1];
   end

   // Stage 4: squared length and dot product.
   always_comb begin
      geom_in.len = scc_pkg::LEN_BITS'(sq_ff[0]) + scc_pkg::LEN_BITS'(sq_ff[1])
                  + scc_pkg::LEN_BITS'(sq_ff[2]);
      geom_in.dot = scc_pkg::DOT_BITS'(dotp_ff[0]) + scc_pkg::DOT_BITS'(dotp_ff[1])
                  + scc_pkg::DOT_BITS'(dotp_ff[2]);
      geom_in.acsq = acsq3_ff;
      geom_in.cos_neg = cneg3_ff;
   end

   // Payload registers follow their stage's advance.
   always_ff @(posedge clock) begin
      if (adv1) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
      end
      if (adv2) begin
         vec_ff <= vec_in;
      end
      if (adv3) begin
         sq_ff    <= sq_in;
         dotp_ff  <= dotp_in;
         acsq3_ff <= acsq3_in;
         cneg3_ff <= cneg3_in;
      end
      if (adv4) begin
         geom_ff <= geom_in;
      end
   end

   assign out_valid = v4_ff;
   assign geom = geom_ff;

endmodule

/* rtl/scc_test.sv */
// Three-stage decision pipeline: distance window and squared angle comparison.
module scc_test (
   input  logic              clock,
   input  logic              reset,
   input  scc_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  scc_pkg::geom_type geom,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              in_cone
);

   typedef struct packed {
      logic win;
      logic len_zero;
      logic dot_neg;
      logic dot_zero;
      logic cos_neg;
   } flag_type;

   logic v5_ff, v6_ff, v7_ff;
   logic v5_in, v6_in, v7_in;
   logic adv5, adv6, adv7;

   logic [scc_pkg::MAG_BITS-1:0] mag;
   logic [scc_pkg::MAG_HI-1:0]   mag_hi;
   logic [scc_pkg::MAG_LO-1:0]   mag_lo;
   logic [scc_pkg::LEN_HI-1:0]   len_hi;
   logic [scc_pkg::LEN_LO-1:0]   len_lo;
   logic [scc_pkg::CMP_BITS-1:0] len_cmp;

   logic [2*scc_pkg::MAG_HI-1:0]                  hh_ff, hh_in;
   logic [scc_pkg::MAG_HI+scc_pkg::MAG_LO-1:0]    hl_ff, hl_in;
   logic [2*scc_pkg::MAG_LO-1:0]                  ll_ff, ll_in;
   logic [scc_pkg::ACSQ_BITS+scc_pkg::LEN_HI-1:0] rh_ff, rh_in;
   logic [scc_pkg::ACSQ_BITS+scc_pkg::LEN_LO-1:0] rl_ff, rl_in;
   flag_type flag5_ff, flag5_in, flag6_ff;

   logic [scc_pkg::WIDE_BITS-1:0] dd_ff, dd_in, rhs_ff, rhs_in;
   logic angle_ok;
   logic cone_ff, cone_in;

   // Per-stage advance; the last stage is the output register.
   assign adv7 = !v7_ff || out_ready;
   assign adv6 = !v6_ff || adv7;
   assign adv5 = !v5_ff || adv6;
   assign in_ready = adv5;

   assign v5_in = adv5 ? in_valid : v5_ff;
   assign v6_in = adv6 ? v5_ff : v6_ff;
   assign v7_in = adv7 ? v6_ff : v7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v5_ff <= v5_in;
         v6_ff <= v6_in;
         v7_ff <= v7_in;
      end
   end

   // Stage 5: magnitude of the dot product, window flags and partial products.
   always_comb begin
      mag = scc_pkg::MAG_BITS'(geom.dot[scc_pkg::DOT_BITS-1] ? -geom.dot : geom.dot);
      mag_hi = mag[scc_pkg::MAG_BITS-1:scc_pkg::MAG_LO];
      mag_lo = mag[scc_pkg::MAG_LO-1:0];
      len_hi = geom.len[scc_pkg::LEN_BITS-1:scc_pkg::LEN_LO];
      len_lo = geom.len[scc_pkg::LEN_LO-1:0];
      len_cmp = scc_pkg::CMP_BITS'(geom.len);

      hh_in = (2*scc_pkg::MAG_HI)'(mag_hi) * (2*scc_pkg::MAG_HI)'(mag_hi);
      hl_in = (scc_pkg::MAG_HI+scc_pkg::MAG_LO)'(mag_hi)
            * (scc_pkg::MAG_HI+scc_pkg::MAG_LO)'(mag_lo);
      ll_in = (2*scc_pkg::MAG_LO)'(mag_lo) * (2*scc_pkg::MAG_LO)'(mag_lo);
      rh_in = (scc_pkg::ACSQ_BITS+scc_pkg::LEN_HI)'(geom.acsq)
            * (scc_pkg::ACSQ_BITS+scc_pkg::LEN_HI)'(len_hi);
      rl_in = (scc_pkg::ACSQ_BITS+scc_pkg::LEN_LO)'(geom.acsq)
            * (scc_pkg::ACSQ_BITS+scc_pkg::LEN_LO)'(len_lo);

      flag5_in.win = (len_cmp <= scc_pkg::CMP_BITS'(cfg.far_radius_sq))
                  && (len_cmp >= scc_pkg::CMP_BITS'(cfg.near_radius_sq));
      flag5_in.len_zero = (geom.len == '0);
      flag5_in.dot_neg  = geom.dot[scc_pkg::DOT_BITS-1];
      flag5_in.dot_zero = (geom.dot == '0);
      flag5_in.cos_neg  = geom.cos_neg;
   end

   // Stage 6: assemble the squared dot product and the scaled length.
   always_comb begin
      dd_in = (scc_pkg::WIDE_BITS'(hh_ff) << (2*scc_pkg::MAG_LO))
            + (scc_pkg::WIDE_BITS'(hl_ff) << (scc_pkg::MAG_LO + 1))
            + scc_pkg::WIDE_BITS'(ll_ff);
      rhs_in = (scc_pkg::WIDE_BITS'(rh_ff) << scc_pkg::LEN_LO) + scc_pkg::WIDE_BITS'(rl_ff);
   end

   // Stage 7: angle decision; a wide cone passes any target not behind the axis.
   always_comb begin
      if (flag6_ff.cos_neg) begin
         angle_ok = !flag6_ff.dot_neg || (dd_ff < rhs_ff);
      end else begin
         angle_ok = !flag6_ff.dot_neg && !flag6_ff.dot_zero && (dd_ff > rhs_ff);
      end
      cone_in = flag6_ff.win && (flag6_ff.len_zero || angle_ok);
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         hh_ff    <= hh_in;
         hl_ff    <= hl_in;
         ll_ff    <= ll_in;
         rh_ff    <= rh_in;
         rl_ff    <= rl_in;
         flag5_ff <= flag5_in;
      end
      if (adv6) begin
         dd_ff    <= dd_in;
         rhs_ff   <= rhs_in;
         flag6_ff <= flag5_ff;
      end
      if (adv7) begin
         cone_ff <= cone_in;
      end
   end

   assign out_valid = v7_ff;
   assign in_cone = cone_ff;

endmodule

/* rtl/sight_cone_containment_test.sv */
// Top level of the sight cone containment test: ports, registers and pipeline halves.
//
//   Channel  Direction  Ports                         Carries
//   req      in         req_tvalid/tready/tdata       observer and target coordinates
//   rsp      out        rsp_tvalid/tready/tdata       in_cone flag
//   csr      in         csr_valid/ready/index/data    register writes, index 0 to 6
//
// One item enters per cycle while req_tready is high. It passes seven register stages of the
// multiply and compare path; the last of them drives rsp_tvalid.
// Reset clears every stage valid bit and loads the register defaults.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and req_tready drops only when all seven stages hold items.
// Register writes are taken in every cycle.
module sight_cone_containment_test (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: origin_x, origin_y, origin_z, target_x, target_y, target_z
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [scc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // tdata: in_cone
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [scc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [scc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   scc_pkg::cfg_type   cfg_ff, cfg_in;
   scc_pkg::query_type query;
   scc_pkg::geom_type  geom;
   logic               geom_valid, geom_ready;
   logic               in_cone;

   // Register file; out-of-range indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            scc_pkg::REG_DIR_X:          cfg_in.dir_x = $signed(csr_data[scc_pkg::AXIS_BITS-1:0]);
            scc_pkg::REG_DIR_Y:          cfg_in.dir_y = $signed(csr_data[scc_pkg::AXIS_BITS-1:0]);
            scc_pkg::REG_DIR_Z:          cfg_in.dir_z = $signed(csr_data[scc_pkg::AXIS_BITS-1:0]);
            scc_pkg::REG_HALF_ANGLE_COS: begin
               cfg_in.half_angle_cos = $signed(csr_data[scc_pkg::AXIS_BITS-1:0]);
            end
            scc_pkg::REG_BACK_OFFSET:    cfg_in.back_offset = csr_data[scc_pkg::OFFSET_BITS-1:0];
            scc_pkg::REG_NEAR_RADIUS_SQ: begin
               cfg_in.near_radius_sq = csr_data[scc_pkg::RADIUS_BITS-1:0];
            end
            scc_pkg::REG_FAR_RADIUS_SQ:  begin
               cfg_in.far_radius_sq = csr_data[scc_pkg::RADIUS_BITS-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dir_x          <= scc_pkg::DIR_X_RESET;
         cfg_ff.dir_y          <= scc_pkg::DIR_Y_RESET;
         cfg_ff.dir_z          <= scc_pkg::DIR_Z_RESET;
         cfg_ff.half_angle_cos <= scc_pkg::COS_RESET;
         cfg_ff.back_offset    <= scc_pkg::OFFSET_RESET;
         cfg_ff.near_radius_sq <= scc_pkg::NEAR_RESET;
         cfg_ff.far_radius_sq  <= scc_pkg::FAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the item fields, first field in the lowest bits.
   always_comb begin
      query.origin_x = $signed(req_tdata[0*scc_pkg::COORD_BITS +: scc_pkg::COORD_BITS]);
      query.origin_y = $signed(req_tdata[1*scc_pkg::COORD_BITS +: scc_pkg::COORD_BITS]);
      query.origin_z = $signed(req_tdata[2*scc_pkg::COORD_BITS +: scc_pkg::COORD_BITS]);
      query.target_x = $signed(req_tdata[3*scc_pkg::COORD_BITS +: scc_pkg::COORD_BITS]);
      query.target_y = $signed(req_tdata[4*scc_pkg::COORD_BITS +: scc_pkg::COORD_BITS]);
      query.target_z = $signed(req_tdata[5*scc_pkg::COORD_BITS +: scc_pkg::COORD_BITS]);
   end

   scc_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .query     (query),
      .out_valid (geom_valid),
      .out_ready (geom_ready),
      .geom      (geom)
   );

   scc_test u_test (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (geom_valid),
      .in_ready  (geom_ready),
      .geom      (geom),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .in_cone   (in_cone)
   );

   assign rsp_tdata = scc_pkg::RSP_DATA_BITS'(in_cone);

endmodule

/* test/sight_cone_containment_test_tb.sv */
// Testbench of the sight cone containment test: directed and random queries checked against a predictor.
module sight_cone_containment_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Index with no register behind it; a write there must change nothing.
   localparam logic [scc_pkg::CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int LONG_HOLD      = 80;
   localparam int GAP_MAX        = 17;

   localparam logic signed [scc_pkg::COORD_BITS-1:0] COORD_MIN =
      {1'b1, {(scc_pkg::COORD_BITS-1){1'b0}}};
   localparam logic signed [scc_pkg::COORD_BITS-1:0] COORD_MAX =
      {1'b0, {(scc_pkg::COORD_BITS-1){1'b1}}};
   localparam logic signed [scc_pkg::AXIS_BITS-1:0]  Q15_MIN   = 16'sh8000;
   localparam logic signed [scc_pkg::AXIS_BITS-1:0]  Q15_MAX   = 16'sh7FFF;
   localparam logic [scc_pkg::OFFSET_BITS-1:0]       OFFSET_MAX = '1;
   localparam logic [scc_pkg::RADIUS_BITS-1:0]       RADIUS_MAX = '1;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [scc_pkg::REQ_DATA_BITS-1:0]  req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [scc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [scc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [scc_pkg::CSR_DATA_BITS-1:0]  csr_data;

   // Register copy used for prediction, and the in_cone values still owed by the block.
   scc_pkg::cfg_type cone_cfg;
   logic             pending_in_cone[$];
   int unsigned      send_gap_max = GAP_MAX;
   int unsigned      recv_gap_max = GAP_MAX;
   int unsigned      hold_request = 0;
   int unsigned      fail_count = 0;
   int unsigned      stall_cycles = 0;

   sight_cone_containment_test dut (.*);

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apex set-back along one axis component, rounded half toward plus infinity.
   function automatic longint setback_units(logic signed [scc_pkg::AXIS_BITS-1:0] axis,
                                            logic [scc_pkg::OFFSET_BITS-1:0] setback);
      longint product;
      product = longint'(axis) * longint'(setback);
      return (product + longint'(scc_pkg::ROUND_HALF)) >>> scc_pkg::FRAC_BITS;
   endfunction

   // Predicts in_cone for one query under the given register settings.
   function automatic logic cone_contains(scc_pkg::query_type q, scc_pkg::cfg_type c);
      longint          vx, vy, vz, dot_v;
      longint unsigned len, dot_mag, cos_mag;
      logic [127:0]    dot_sq, cos_bound;
      vx = longint'(q.target_x) - longint'(q.origin_x) + setback_units(c.dir_x, c.back_offset);
      vy = longint'(q.target_y) - longint'(q.origin_y) + setback_units(c.dir_y, c.back_offset);
      vz = longint'(q.target_z) - longint'(q.origin_z) + setback_units(c.dir_z, c.back_offset);
      len = vx * vx + vy * vy + vz * vz;
      // Distance window first, both bounds inclusive.
      if (len > c.far_radius_sq || len < c.near_radius_sq)
         return 1'b0;
      if (len == 0)
         return 1'b1;
      // Angle test on squares, with the sign of the dot product handled apart.
      dot_v = vx * longint'(c.dir_x) + vy * longint'(c.dir_y) + vz * longint'(c.dir_z);
      dot_mag = (dot_v < 0) ? -dot_v : dot_v;
      cos_mag = (c.half_angle_cos < 0) ? -longint'(c.half_angle_cos)
                                       : longint'(c.half_angle_cos);
      dot_sq = {64'd0, dot_mag} * {64'd0, dot_mag};
      cos_bound = {64'd0, cos_mag * cos_mag} * {64'd0, len};
      if (c.half_angle_cos < 0)
         return (dot_v >= 0) || (dot_sq < cos_bound);
      return (dot_v > 0) && (dot_sq > cos_bound);
   endfunction

   function automatic scc_pkg::query_type point_pair(int ox, int oy, int oz,
                                                     int tx, int ty, int tz);
      scc_pkg::query_type q;
      q.origin_x = scc_pkg::COORD_BITS'(ox);
      q.origin_y = scc_pkg::COORD_BITS'(oy);
      q.origin_z = scc_pkg::COORD_BITS'(oz);
      q.target_x = scc_pkg::COORD_BITS'(tx);
      q.target_y = scc_pkg::COORD_BITS'(ty);
      q.target_z = scc_pkg::COORD_BITS'(tz);
      return q;
   endfunction

   function automatic logic signed [scc_pkg::COORD_BITS-1:0] draw_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         default: return scc_pkg::COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic signed [scc_pkg::AXIS_BITS-1:0] draw_q15();
      case ($urandom_range(0, 5))
         0: return Q15_MIN;
         1: return Q15_MAX;
         2: return '0;
         default: return scc_pkg::AXIS_BITS'($urandom);
      endcase
   endfunction

   // Squared radius spread over all magnitudes.
   function automatic logic [scc_pkg::RADIUS_BITS-1:0] draw_radius_sq();
      logic [scc_pkg::RADIUS_BITS-1:0] r;
      r = scc_pkg::RADIUS_BITS'({$urandom, $urandom});
      return r >> $urandom_range(0, scc_pkg::RADIUS_BITS - 1);
   endfunction

   // Coordinate placed near the cone axis: apex set-back undone, a step along
   // the axis, and some jitter around it.
   function automatic logic signed [scc_pkg::COORD_BITS-1:0] near_axis(
         logic signed [scc_pkg::COORD_BITS-1:0] origin,
         logic signed [scc_pkg::AXIS_BITS-1:0] axis,
         longint reach, int span);
      longint spot;
      spot = longint'(origin) - setback_units(axis, cone_cfg.back_offset)
             + ((longint'(axis) * reach) >>> scc_pkg::FRAC_BITS)
             + longint'($urandom_range(0, 2 * span)) - span;
      return scc_pkg::COORD_BITS'(spot);
   endfunction

   // Random query: mostly targets near the cone axis, the rest anywhere.
   function automatic scc_pkg::query_type draw_query();
      scc_pkg::query_type q;
      longint             reach;
      int                 span;
      q.origin_x = draw_coord();
      q.origin_y = draw_coord();
      q.origin_z = draw_coord();
      case ($urandom_range(0, 4))
         0, 1: begin
            q.target_x = draw_coord();
            q.target_y = draw_coord();
            q.target_z = draw_coord();
            return q;
         end
         2, 3: begin
            reach = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
            span = 1 << $urandom_range(0, 10);
         end
         default: begin
            reach = 0;
            span = 1;
         end
      endcase
      q.target_x = near_axis(q.origin_x, cone_cfg.dir_x, reach, span);
      q.target_y = near_axis(q.origin_y, cone_cfg.dir_y, reach, span);
      q.target_z = near_axis(q.origin_z, cone_cfg.dir_z, reach, span);
      return q;
   endfunction

   // A 16-bit register value with random bits above it, which the block ignores.
   function automatic logic [scc_pkg::CSR_DATA_BITS-1:0] pad_field(
         logic [scc_pkg::AXIS_BITS-1:0] v);
      logic [scc_pkg::CSR_DATA_BITS-1:0] w;
      w = scc_pkg::CSR_DATA_BITS'({$urandom, $urandom});
      w[scc_pkg::AXIS_BITS-1:0] = v;
      return w;
   endfunction

   // Sends one item after a random gap; valid stays high for a following item.
   task automatic send_query(scc_pkg::query_type q);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {q.target_z, q.target_y, q.target_x, q.origin_z, q.origin_y, q.origin_x};
      do @(posedge clock); while (!req_tready);
      pending_in_cone.push_back(cone_contains(q, cone_cfg));
   endtask

   // Stops offering items and waits until every result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_in_cone.size() != 0) @(posedge clock);
   endtask

   // One register write; the caller lowers csr_valid after its last write.
   task automatic write_reg(logic [scc_pkg::CSR_INDEX_BITS-1:0] index,
                            logic [scc_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         scc_pkg::REG_DIR_X:          cone_cfg.dir_x = value[scc_pkg::AXIS_BITS-1:0];
         scc_pkg::REG_DIR_Y:          cone_cfg.dir_y = value[scc_pkg::AXIS_BITS-1:0];
         scc_pkg::REG_DIR_Z:          cone_cfg.dir_z = value[scc_pkg::AXIS_BITS-1:0];
         scc_pkg::REG_HALF_ANGLE_COS: begin
            cone_cfg.half_angle_cos = value[scc_pkg::AXIS_BITS-1:0];
         end
         scc_pkg::REG_BACK_OFFSET:    cone_cfg.back_offset = value[scc_pkg::OFFSET_BITS-1:0];
         scc_pkg::REG_NEAR_RADIUS_SQ: begin
            cone_cfg.near_radius_sq = value[scc_pkg::RADIUS_BITS-1:0];
         end
         scc_pkg::REG_FAR_RADIUS_SQ:  begin
            cone_cfg.far_radius_sq = value[scc_pkg::RADIUS_BITS-1:0];
         end
         default: ;
      endcase
   endtask

   // Writes every register once the block is idle.
   task automatic apply_config(scc_pkg::cfg_type want_cfg);
      wait_drained();
      write_reg(scc_pkg::REG_DIR_X, pad_field(want_cfg.dir_x));
      write_reg(scc_pkg::REG_DIR_Y, pad_field(want_cfg.dir_y));
      write_reg(scc_pkg::REG_DIR_Z, pad_field(want_cfg.dir_z));
      write_reg(scc_pkg::REG_HALF_ANGLE_COS, pad_field(want_cfg.half_angle_cos));
      write_reg(scc_pkg::REG_BACK_OFFSET, pad_field(want_cfg.back_offset));
      write_reg(scc_pkg::REG_NEAR_RADIUS_SQ, want_cfg.near_radius_sq);
      write_reg(scc_pkg::REG_FAR_RADIUS_SQ, want_cfg.far_radius_sq);
      csr_valid <= 1'b0;
   endtask

   // Reset settings: zero vector, straight ahead, behind, just outside 45 degrees,
   // and the coordinate extremes.
   task automatic test_reset_defaults();
      send_query(point_pair(0, 0, 0, 0, 0, 0));
      send_query(point_pair(0, 0, 0, 100, 0, 0));
      send_query(point_pair(0, 0, 0, -100, 0, 0));
      send_query(point_pair(0, 0, 0, 1, 1, 0));
      send_query(point_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_query(point_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
   endtask

   // Distance window: inclusive bounds, crossed bounds, zero vector at both ends.
   task automatic test_window_bounds();
      scc_pkg::cfg_type window_cfg;
      window_cfg = cone_cfg;
      window_cfg.near_radius_sq = 25;
      window_cfg.far_radius_sq = 25;
      apply_config(window_cfg);
      send_query(point_pair(0, 0, 0, 5, 0, 0));
      send_query(point_pair(0, 0, 0, 4, 0, 0));
      send_query(point_pair(0, 0, 0, 6, 0, 0));
      send_query(point_pair(0, 0, 0, 3, 4, 0));
      window_cfg.near_radius_sq = 26;
      apply_config(window_cfg);
      send_query(point_pair(0, 0, 0, 5, 0, 0));
      window_cfg.near_radius_sq = 1;
      window_cfg.far_radius_sq = RADIUS_MAX;
      apply_config(window_cfg);
      send_query(point_pair(9, 9, 9, 9, 9, 9));
      window_cfg.near_radius_sq = RADIUS_MAX;
      apply_config(window_cfg);
      send_query(point_pair(0, 0, 0, 1000, 0, 0));
      window_cfg.near_radius_sq = 0;
      window_cfg.far_radius_sq = 0;
      apply_config(window_cfg);
      send_query(point_pair(-4, 7, 1, -4, 7, 1));
      send_query(point_pair(0, 0, 0, 1, 0, 0));
   endtask

   // Apex set-back: halves round up, values just below a half round down,
   // and the largest set-back on extreme axis values.
   task automatic test_apex_rounding();
      scc_pkg::cfg_type apex_cfg;
      apex_cfg = cone_cfg;
      apex_cfg.dir_x = 1;
      apex_cfg.dir_y = -1;
      apex_cfg.dir_z = 0;
      apex_cfg.half_angle_cos = Q15_MIN;
      apex_cfg.back_offset = 16384;
      apex_cfg.near_radius_sq = 1;
      apex_cfg.far_radius_sq = 1;
      apply_config(apex_cfg);
      send_query(point_pair(7, -3, 2, 7, -3, 2));
      send_query(point_pair(7, -3, 2, 6, -3, 2));
      apex_cfg.back_offset = 16383;
      apply_config(apex_cfg);
      send_query(point_pair(0, 0, 0, 0, 0, 0));
      apex_cfg.dir_x = Q15_MIN;
      apex_cfg.dir_y = Q15_MAX;
      apex_cfg.dir_z = Q15_MIN;
      apex_cfg.half_angle_cos = Q15_MAX;
      apex_cfg.back_offset = OFFSET_MAX;
      apex_cfg.near_radius_sq = 0;
      apex_cfg.far_radius_sq = RADIUS_MAX;
      apply_config(apex_cfg);
      send_query(point_pair(0, 0, 0, 0, 0, 0));
      send_query(point_pair(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
   endtask

   // Cone half angle: zero cosine, negative cosine on both sides of the
   // boundary, and the two extremes, the positive one with a tie on the boundary.
   task automatic test_cos_sign();
      scc_pkg::cfg_type cos_cfg;
      cos_cfg = cone_cfg;
      cos_cfg.dir_x = 0;
      cos_cfg.dir_y = Q15_MAX;
      cos_cfg.dir_z = 0;
      cos_cfg.back_offset = 0;
      cos_cfg.near_radius_sq = 0;
      cos_cfg.far_radius_sq = RADIUS_MAX;
      cos_cfg.half_angle_cos = 0;
      apply_config(cos_cfg);
      send_query(point_pair(0, 0, 0, 1, 0, 0));
      send_query(point_pair(0, 0, 0, 0, 1, 0));
      send_query(point_pair(0, 0, 0, 0, -1, 0));
      cos_cfg.half_angle_cos = -16384;
      apply_config(cos_cfg);
      send_query(point_pair(0, 0, 0, 1, 0, 0));
      send_query(point_pair(0, 0, 0, 1, -1, 0));
      send_query(point_pair(0, 0, 0, 10, -1, 0));
      cos_cfg.half_angle_cos = Q15_MIN;
      apply_config(cos_cfg);
      send_query(point_pair(0, 0, 0, 0, -1, 0));
      cos_cfg.half_angle_cos = Q15_MAX;
      apply_config(cos_cfg);
      send_query(point_pair(0, 0, 0, 0, 1, 0));
   endtask

   // A write to the unused index leaves every register as it was.
   task automatic test_unused_index();
      wait_drained();
      write_reg(REG_UNUSED, RADIUS_MAX);
      csr_valid <= 1'b0;
      send_query(point_pair(0, 0, 0, 0, 100, 0));
      send_query(point_pair(0, 0, 0, 5, -3, 2));
   endtask

   // The receiver holds off for a long stretch while items keep coming,
   // so the pipeline fills and stalls its input.
   task automatic test_backpressure();
      send_gap_max = 0;
      recv_gap_max = 0;
      hold_request = LONG_HOLD;
      repeat (30) send_query(draw_query());
   endtask

   // Random settings per phase, random idling profile, random queries.
   task automatic test_random_queries();
      scc_pkg::cfg_type rand_cfg;
      repeat (10) begin
         rand_cfg.dir_x = draw_q15();
         rand_cfg.dir_y = draw_q15();
         rand_cfg.dir_z = draw_q15();
         rand_cfg.half_angle_cos = draw_q15();
         case ($urandom_range(0, 3))
            0: rand_cfg.back_offset = 0;
            1: rand_cfg.back_offset = OFFSET_MAX;
            default: rand_cfg.back_offset = scc_pkg::OFFSET_BITS'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0, 1: begin
               rand_cfg.near_radius_sq = 0;
               rand_cfg.far_radius_sq = RADIUS_MAX;
            end
            2: begin
               rand_cfg.near_radius_sq = draw_radius_sq();
               rand_cfg.far_radius_sq = rand_cfg.near_radius_sq + draw_radius_sq();
            end
            3: begin
               rand_cfg.near_radius_sq = draw_radius_sq();
               rand_cfg.far_radius_sq = draw_radius_sq();
            end
            4: begin
               rand_cfg.near_radius_sq = 0;
               rand_cfg.far_radius_sq = draw_radius_sq();
            end
            default: begin
               rand_cfg.near_radius_sq = draw_radius_sq();
               rand_cfg.far_radius_sq = RADIUS_MAX;
            end
         endcase
         apply_config(rand_cfg);
         // Idling profile of this phase, including runs with no gaps at all.
         case ($urandom_range(0, 3))
            0: begin send_gap_max = 0;       recv_gap_max = 0;       end
            1: begin send_gap_max = GAP_MAX; recv_gap_max = 0;       end
            2: begin send_gap_max = 0;       recv_gap_max = GAP_MAX; end
            default: begin send_gap_max = GAP_MAX; recv_gap_max = GAP_MAX; end
         endcase
         repeat (200) send_query(draw_query());
      end
   endtask

   // Result side: random ready gaps, long hold-offs on request, and the
   // comparison of each result with the oldest prediction.
   initial begin : result_check
      int unsigned ready_hold;
      logic        expected;
      ready_hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_in_cone.size() == 0) begin
               $display("%0t: result with none expected, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               expected = pending_in_cone.pop_front();
               if (rsp_tdata !== {{(scc_pkg::RSP_DATA_BITS-1){1'b0}}, expected}) begin
                  $display("%0t: in_cone mismatch, expected %h, actual %h", $time,
                           {{(scc_pkg::RSP_DATA_BITS-1){1'b0}}, expected}, rsp_tdata);
                  fail_count++;
               end
            end
            ready_hold = $urandom_range(0, recv_gap_max);
         end
         if (rsp_tready) begin
            if (hold_request != 0) begin
               ready_hold = hold_request;
               hold_request = 0;
            end
            if (ready_hold != 0)
               rsp_tready <= 1'b0;
         end else if (ready_hold <= 1) begin
            ready_hold = 0;
            rsp_tready <= 1'b1;
         end else begin
            ready_hold--;
         end
      end
   end

   // Watchdog: too many cycles in a row with no item moving on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      cone_cfg = '{dir_x: scc_pkg::DIR_X_RESET, dir_y: scc_pkg::DIR_Y_RESET,
                   dir_z: scc_pkg::DIR_Z_RESET, half_angle_cos: scc_pkg::COS_RESET,
                   back_offset: scc_pkg::OFFSET_RESET,
                   near_radius_sq: scc_pkg::NEAR_RESET,
                   far_radius_sq: scc_pkg::FAR_RESET};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_window_bounds();
      test_apex_rounding();
      test_cos_sign();
      test_unused_index();
      test_backpressure();
      test_random_queries();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
